[hw/rtl/sacl_pkg.sv]
// sacl_pkg: shared constants and types for the sorted age/count list.
// Used by sacl_cell, sorted_age_count_list and sacl_checker. No dependencies.
package sacl_pkg;

	localparam int SLOTS   = 16;
	localparam int AGE_W   = 32;
	localparam int CNT_W   = 16;
	localparam int USED_W  = $clog2(SLOTS + 1);
	localparam int INUSE_W = 5;
	localparam int IN_W    = 48;
	localparam int OUT_W   = 24;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	typedef enum logic [1:0] {
		OP_NONE,
		OP_MERGE,
		OP_INSERT,
		OP_DELETE
	} op_t;

	typedef struct packed {
		logic             mode;
		logic [AGE_W-1:0] age;
		logic [CNT_W-1:0] amount;
	} cmd_t;

	// what a cell shows its neighbors
	typedef struct packed {
		logic             valid;
		logic             ge;
		logic [AGE_W-1:0] age;
		logic [CNT_W-1:0] count;
	} link_t;

	// what a cell reports to the list control
	typedef struct packed {
		logic             eq;
		logic             rm_all;
		logic [CNT_W-1:0] report;
	} flag_t;

endpackage

[hw/rtl/sacl_cell.sv]
// sacl_cell: one slot of the sorted list, holding a valid bit, an age and a count.
// Compares its age against the broadcast word and shifts with its neighbors.
// Depends on sacl_pkg.
module sacl_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  sacl_pkg::cmd_t  cmd,
	input  sacl_pkg::op_t   op,
	input  sacl_pkg::link_t left,
	input  sacl_pkg::link_t right,
	output sacl_pkg::link_t link,
	output sacl_pkg::flag_t flags
);
	import sacl_pkg::*;

	logic             valid_q;
	logic [AGE_W-1:0] age_q;
	logic [CNT_W-1:0] count_q;

	logic             eq;
	logic             ge;
	logic [CNT_W:0]   sum;
	logic [CNT_W-1:0] sat_sum;
	logic [CNT_W-1:0] diff;
	logic             rm_all;
	logic [CNT_W-1:0] new_count;

	assign eq      = valid_q && (age_q == cmd.age);
	assign ge      = valid_q && (age_q >= cmd.age);
	assign sum     = {1'b0, count_q} + {1'b0, cmd.amount};
	assign sat_sum = sum[CNT_W] ? COUNT_MAX : sum[CNT_W-1:0];
	assign diff    = count_q - cmd.amount;
	assign rm_all  = cmd.amount >= count_q;

	always_comb begin
		if (cmd.mode) begin
			new_count = rm_all ? '0 : diff;
		end else begin
			new_count = sat_sum;
		end
	end

	assign link  = '{valid: valid_q, ge: ge, age: age_q, count: count_q};
	assign flags = '{eq: eq, rm_all: eq && rm_all, report: eq ? new_count : '0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			unique case (op)
				OP_INSERT: begin
					if (ge || (!valid_q && left.valid)) begin
						valid_q <= 1'b1;
					end
				end
				OP_DELETE: begin
					if (ge) begin
						valid_q <= right.valid;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			OP_MERGE: begin
				if (eq) begin
					count_q <= new_count;
				end
			end
			OP_INSERT: begin
				if (ge || (!valid_q && left.valid)) begin
					if (left.ge) begin
						age_q   <= left.age;
						count_q <= left.count;
					end else begin
						age_q   <= cmd.age;
						count_q <= cmd.amount;
					end
				end
			end
			OP_DELETE: begin
				if (ge) begin
					age_q   <= right.age;
					count_q <= right.count;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

[hw/rtl/sorted_age_count_list.sv]
// Sorted age/count list: up to SLOTS (age, count) entries kept in ascending age
// order in a row of cells. Every cell compares its age against the incoming word
// in the same cycle, so one word is taken per clock and its result appears in
// the output register on the next cycle; the input is stalled only while that
// register is full and not taken. Counts saturate at 65535. No clearing pass.
module sorted_age_count_list (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [sacl_pkg::IN_W-1:0]   s_axis_tdata,  // age[31:0], amount[47:32]
	input  logic                        s_axis_tuser,  // mode: 0 add, 1 remove
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [sacl_pkg::OUT_W-1:0]  m_axis_tdata   // hit[0], rejected[1],
	                                                   // entry_count_after[17:2],
	                                                   // entries_in_use[22:18], zero
);
	import sacl_pkg::*;

	cmd_t             cmd;
	op_t              op;
	link_t            links [SLOTS];
	flag_t            flags [SLOTS];
	link_t            lefts [SLOTS];
	link_t            rights[SLOTS];
	logic             accept;
	logic             found;
	logic             del_any;
	logic             full;
	logic             rejected;
	logic [CNT_W-1:0] after;
	logic [USED_W-1:0] used_q;
	logic [USED_W-1:0] used_d;
	logic             m_valid_q;
	logic [OUT_W-1:0] m_data_q;

	assign cmd    = '{mode: s_axis_tuser, age: s_axis_tdata[AGE_W-1:0],
	                  amount: s_axis_tdata[AGE_W+CNT_W-1:AGE_W]};
	assign s_axis_tready = !m_valid_q || m_axis_tready;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign full   = links[SLOTS-1].valid;

	always_comb begin
		found   = 1'b0;
		del_any = 1'b0;
		after   = '0;
		for (int i = 0; i < SLOTS; i++) begin
			found   = found | flags[i].eq;
			del_any = del_any | flags[i].rm_all;
			after   = after | flags[i].report;
		end
	end

	assign rejected = !cmd.mode && !found && (cmd.amount != '0) && full;

	always_comb begin
		op = OP_NONE;
		if (accept) begin
			if (found) begin
				op = (cmd.mode && del_any) ? OP_DELETE : OP_MERGE;
			end else if (!cmd.mode && (cmd.amount != '0) && !full) begin
				op = OP_INSERT;
			end
		end
	end

	always_comb begin
		unique case (op)
			OP_INSERT: used_d = used_q + 1'b1;
			OP_DELETE: used_d = used_q - 1'b1;
			default:   used_d = used_q;
		endcase
	end

	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		if (g == 0) begin : g_head
			assign lefts[g] = '{valid: 1'b1, ge: 1'b0, age: '0, count: '0};
		end else begin : g_mid
			assign lefts[g] = links[g-1];
		end
		if (g == SLOTS - 1) begin : g_tail
			assign rights[g] = '{valid: 1'b0, ge: 1'b0, age: '0, count: '0};
		end else begin : g_body
			assign rights[g] = links[g+1];
		end
		sacl_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.cmd   (cmd),
			.op    (op),
			.left  (lefts[g]),
			.right (rights[g]),
			.link  (links[g]),
			.flags (flags[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			used_q <= used_d;
			if (accept) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_data_q <= OUT_W'({INUSE_W'(used_d),
			                    (op == OP_INSERT) ? cmd.amount : after,
			                    rejected, found});
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

[hw/rtl/sacl_checker.sv]
// sacl_checker: port-level assertions for sorted_age_count_list, bound to the top.
// Depends on sacl_pkg.
module sacl_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_axis_tvalid,
	input logic                        s_axis_tready,
	input logic [sacl_pkg::IN_W-1:0]   s_axis_tdata,
	input logic                        s_axis_tuser,
	input logic                        m_axis_tvalid,
	input logic                        m_axis_tready,
	input logic [sacl_pkg::OUT_W-1:0]  m_axis_tdata
);
	import sacl_pkg::*;

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output register");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
		else $error("accepted word produced no result");

	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[1]) |->
		(!m_axis_tdata[0] && (m_axis_tdata[17:2] == '0)))
		else $error("reject with hit or nonzero count");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("stalled result changed");

endmodule

bind sorted_age_count_list sacl_checker u_sacl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tdata (s_axis_tdata),
	.s_axis_tuser (s_axis_tuser),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);
